/* rtl/fenrp_pkg.sv */
// fenrp_pkg: shared types and constants for the FEN record parser.
// No dependencies; imported by fen_record_parser.
`default_nettype none

package fenrp_pkg;

   // width of the halfmove / fullmove accumulators
   localparam int COUNT_BITS = 16;

   // result queue depth and its count width
   localparam int QDEPTH   = 4;
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // result kinds
   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_PIECE   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // field indexes within a record
   localparam logic [2:0] FLD_BOARD  = 3'd0;
   localparam logic [2:0] FLD_SIDE   = 3'd1;
   localparam logic [2:0] FLD_CASTLE = 3'd2;
   localparam logic [2:0] FLD_EP     = 3'd3;
   localparam logic [2:0] FLD_HALF   = 3'd4;
   localparam logic [2:0] FLD_FULL   = 3'd5;
   localparam logic [2:0] FLD_MAX    = 3'd7;

   // valid_mask bits
   localparam int VB_BOARD  = 0;
   localparam int VB_SIDE   = 1;
   localparam int VB_CASTLE = 2;
   localparam int VB_EP     = 3;
   localparam int VB_HALF   = 4;
   localparam int VB_FULL   = 5;

   // number flag bits
   localparam int NF_DIGITS  = 0;
   localparam int NF_NEG     = 1;
   localparam int NF_BAD     = 2;
   localparam int NF_OVF     = 3;
   localparam int NF_STARTED = 4;

   // castle accumulator bits
   localparam int CB_WK  = 0;
   localparam int CB_WQ  = 1;
   localparam int CB_BK  = 2;
   localparam int CB_BQ  = 3;
   localparam int CB_BAD = 4;

   // characters
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LH    = 8'h68;
   localparam logic [7:0] CH_LW    = 8'h77;
   localparam logic [7:0] CH_UP_P  = 8'h50;
   localparam logic [7:0] CH_UP_N  = 8'h4E;
   localparam logic [7:0] CH_UP_B  = 8'h42;
   localparam logic [7:0] CH_UP_R  = 8'h52;
   localparam logic [7:0] CH_UP_Q  = 8'h51;
   localparam logic [7:0] CH_UP_K  = 8'h4B;
   localparam logic [7:0] CH_LO_P  = 8'h70;
   localparam logic [7:0] CH_LO_N  = 8'h6E;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_Q  = 8'h71;
   localparam logic [7:0] CH_LO_K  = 8'h6B;

   // piece codes
   localparam logic [3:0] PC_WP = 4'd0;
   localparam logic [3:0] PC_WN = 4'd1;
   localparam logic [3:0] PC_WB = 4'd2;
   localparam logic [3:0] PC_WR = 4'd3;
   localparam logic [3:0] PC_WQ = 4'd4;
   localparam logic [3:0] PC_WK = 4'd5;
   localparam logic [3:0] PC_BP = 4'd6;
   localparam logic [3:0] PC_BN = 4'd7;
   localparam logic [3:0] PC_BB = 4'd8;
   localparam logic [3:0] PC_BR = 4'd9;
   localparam logic [3:0] PC_BQ = 4'd10;
   localparam logic [3:0] PC_BK = 4'd11;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_record;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  square_rank;
      logic [2:0]  square_file;
      logic [3:0]  piece_code;
      logic [5:0]  valid_mask;
      logic        side_black;
      logic [3:0]  castle_bits;
      logic        en_passant_set;
      logic [15:0] halfmove_count;
      logic [15:0] fullmove_count;
      logic        last;
   } rsp_type;

   // per-record parse state
   typedef struct packed {
      logic                  in_record;
      logic [2:0]            field_index;
      logic [3:0]            rank_index;
      logic [3:0]            file_count;
      logic                  board_bad;
      logic                  slash_pending;
      logic [1:0]            field_length;
      logic [7:0]            first_char;
      logic [7:0]            second_char;
      logic [4:0]            castle_acc;
      logic [COUNT_BITS-1:0] number_acc;
      logic [4:0]            number_flags;
      logic [5:0]            valid_acc;
      logic [COUNT_BITS-1:0] halfmove_hold;
      logic                  side_hold;
   } pst_type;

endpackage

`default_nettype wire

/* rtl/fen_record_parser.sv */
// fen_record_parser: streaming FEN line parser, one byte per word.
// Depends on fenrp_pkg (types, character and field constants).
//
//   channel  direction  payload   handshake
//   req      in         req_type  req_valid / req_ready
//   rsp      out        rsp_type  rsp_valid / rsp_ready
//
// Each accepted byte updates the parse state and pushes 0..3
// results into a 4-entry result queue; rsp is driven from the queue head.
// Throughput is one byte per cycle while each byte yields at most one result
// and rsp keeps up; req_ready drops while two or more results are queued.
// Results are written into the registered queue when their byte is accepted.
// Synchronous active-high reset clears parse state and empties the queue.
`default_nettype none

module fen_record_parser
   import fenrp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   pst_type            st_ff, st_in, st;
   rsp_type            q_ff [QDEPTH];
   rsp_type            q_in [QDEPTH];
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [QCNT_W-1:0]  base, off;

   rsp_type            clr_res, pc_res, sm_res;
   rsp_type            res [3];
   logic               clr_v, pc_v, sm_v;
   logic [1:0]         n_res;
   logic               fire, pop;

   logic [7:0]         c;
   logic [1:0]         len;
   logic [4:0]         pinfo;
   logic [4:0]         fsum;
   logic [3:0]         tokens;

   // {valid, code}
   function automatic logic [4:0] piece_of(logic [7:0] ch);
      logic [4:0] r;
      r = '0;
      case (ch)
         CH_UP_P: r = {1'b1, PC_WP};
         CH_UP_N: r = {1'b1, PC_WN};
         CH_UP_B: r = {1'b1, PC_WB};
         CH_UP_R: r = {1'b1, PC_WR};
         CH_UP_Q: r = {1'b1, PC_WQ};
         CH_UP_K: r = {1'b1, PC_WK};
         CH_LO_P: r = {1'b1, PC_BP};
         CH_LO_N: r = {1'b1, PC_BN};
         CH_LO_B: r = {1'b1, PC_BB};
         CH_LO_R: r = {1'b1, PC_BR};
         CH_LO_Q: r = {1'b1, PC_BQ};
         CH_LO_K: r = {1'b1, PC_BK};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic number_ok(pst_type s, logic need_one);
      logic ok;
      ok = s.number_flags[NF_DIGITS] && !s.number_flags[NF_OVF];
      if (s.number_flags[NF_NEG] && s.number_acc != '0) ok = 1'b0;
      if (need_one && s.number_acc == '0) ok = 1'b0;
      return ok;
   endfunction

   function automatic pst_type number_char(pst_type s, logic [7:0] ch);
      logic                  digit, take;
      logic [COUNT_BITS+3:0] wide, prod;
      digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      take  = 1'b0;
      wide  = {4'b0, s.number_acc};
      prod  = (wide << 3) + (wide << 1) + (COUNT_BITS+4)'(ch[3:0]);
      if (!s.number_flags[NF_BAD]) begin
         if (!s.number_flags[NF_STARTED]) begin
            // leading blanks, then an optional sign
            if (ch >= CH_TAB && ch <= CH_CR) begin
               take = 1'b0;
            end else if (ch == CH_PLUS || ch == CH_DASH) begin
               s.number_flags[NF_STARTED] = 1'b1;
               if (ch == CH_DASH) s.number_flags[NF_NEG] = 1'b1;
            end else if (!digit) begin
               s.number_flags[NF_BAD] = 1'b1;
            end else begin
               s.number_flags[NF_STARTED] = 1'b1;
               take = 1'b1;
            end
         end else if (!digit) begin
            s.number_flags[NF_BAD] = 1'b1;
         end else begin
            take = 1'b1;
         end
      end
      if (take) begin
         s.number_flags[NF_DIGITS] = 1'b1;
         if (!s.number_flags[NF_OVF]) begin
            s.number_acc = prod[COUNT_BITS-1:0];
            if (prod[COUNT_BITS+3:COUNT_BITS] != '0) s.number_flags[NF_OVF] = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic pst_type finish_field(pst_type s);
      logic ok;
      ok = 1'b0;
      case (s.field_index)
         FLD_BOARD: begin
            ok = !s.board_bad &&
                 ((s.slash_pending && s.rank_index == 4'd8) ||
                  (!s.slash_pending && s.rank_index == 4'd7 && s.file_count == 4'd8));
            s.valid_acc[VB_BOARD] = ok;
         end
         FLD_SIDE: begin
            ok = s.field_length == 2'd1 &&
                 (s.first_char == CH_LW || s.first_char == CH_LO_B);
            s.side_hold = ok && s.first_char == CH_LO_B;
            s.valid_acc[VB_SIDE] = ok;
         end
         FLD_CASTLE: begin
            s.valid_acc[VB_CASTLE] = !s.castle_acc[CB_BAD];
         end
         FLD_EP: begin
            ok = (s.field_length == 2'd1 && s.first_char == CH_DASH) ||
                 (s.field_length == 2'd2 &&
                  s.first_char >= CH_LA && s.first_char <= CH_LH &&
                  s.second_char >= CH_ONE && s.second_char <= CH_EIGHT);
            s.valid_acc[VB_EP] = ok;
         end
         FLD_HALF: begin
            ok = number_ok(s, 1'b0);
            s.halfmove_hold = ok ? s.number_acc : '0;
            s.valid_acc[VB_HALF] = ok;
         end
         FLD_FULL: begin
            s.valid_acc[VB_FULL] = number_ok(s, 1'b1);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return s;
   endfunction

   assign fire      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = cnt_ff < QCNT_W'(2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_ff[0];
   assign c         = req_data.char_code;

   // parse step for one byte
   always_comb begin
      st      = st_ff;
      clr_v   = 1'b0;
      pc_v    = 1'b0;
      sm_v    = 1'b0;
      clr_res = '0;
      pc_res  = '0;
      sm_res  = '0;
      len     = '0;
      pinfo   = piece_of(c);
      fsum    = '0;
      tokens  = '0;

      if (!st.in_record) begin
         st           = '0;
         st.in_record = 1'b1;
         clr_v        = 1'b1;
         clr_res.result_kind = KIND_CLEAR;
      end

      if (c == CH_SPACE) begin
         st = finish_field(st);
         if (st.field_index != FLD_MAX) st.field_index = st.field_index + 3'd1;
         st.field_length = '0;
         if (st.field_index == FLD_CASTLE) st.castle_acc = '0;
         if (st.field_index == FLD_HALF || st.field_index == FLD_FULL) begin
            st.number_acc   = '0;
            st.number_flags = '0;
         end
      end else begin
         len = st.field_length;
         if (st.field_length != 2'd3) st.field_length = st.field_length + 2'd1;
         case (st.field_index)
            FLD_BOARD: begin
               if (c == CH_SLASH) begin
                  if (st.rank_index >= 4'd8 || st.file_count != 4'd8) st.board_bad = 1'b1;
                  if (st.rank_index < 4'd8) st.rank_index = st.rank_index + 4'd1;
                  st.file_count    = '0;
                  st.slash_pending = 1'b1;
               end else begin
                  st.slash_pending = 1'b0;
                  if (c >= CH_ONE && c <= CH_EIGHT) begin
                     fsum = {1'b0, st.file_count} + {1'b0, c[3:0]};
                     if (st.rank_index >= 4'd8 || fsum > 5'd8) st.board_bad = 1'b1;
                     else st.file_count = fsum[3:0];
                  end else if (!pinfo[4] || st.rank_index >= 4'd8 ||
                               st.file_count >= 4'd8) begin
                     st.board_bad = 1'b1;
                  end else if (st.board_bad) begin
                     // board already rejected: keep counting, emit nothing
                     st.file_count = st.file_count + 4'd1;
                  end else begin
                     pc_v                = 1'b1;
                     pc_res.result_kind  = KIND_PIECE;
                     pc_res.square_rank  = ~st.rank_index[2:0];
                     pc_res.square_file  = st.file_count[2:0];
                     pc_res.piece_code   = pinfo[3:0];
                     st.file_count       = st.file_count + 4'd1;
                  end
               end
            end
            FLD_SIDE: begin
               if (len == 2'd0) st.first_char = c;
            end
            FLD_CASTLE: begin
               priority if (c == CH_UP_K) st.castle_acc[CB_WK] = 1'b1;
               else if (c == CH_UP_Q)     st.castle_acc[CB_WQ] = 1'b1;
               else if (c == CH_LO_K)     st.castle_acc[CB_BK] = 1'b1;
               else if (c == CH_LO_Q)     st.castle_acc[CB_BQ] = 1'b1;
               else if (c != CH_DASH)     st.castle_acc[CB_BAD] = 1'b1;
               else                       st.castle_acc = st.castle_acc;
            end
            FLD_EP: begin
               if (len == 2'd0) st.first_char = c;
               else if (len == 2'd1) st.second_char = c;
            end
            FLD_HALF, FLD_FULL: begin
               st = number_char(st, c);
            end
            default: begin
               st = st;
            end
         endcase
      end

      if (req_data.end_of_record) begin
         st     = finish_field(st);
         tokens = {1'b0, st.field_index} + {3'b0, st.field_length != 2'd0};
         sm_v   = 1'b1;
         sm_res.result_kind = KIND_SUMMARY;
         if (st.valid_acc[VB_BOARD] && tokens >= 4'd6) begin
            sm_res.valid_mask  = st.valid_acc;
            sm_res.side_black  = st.side_hold;
            sm_res.castle_bits = st.valid_acc[VB_CASTLE] ? st.castle_acc[3:0] : 4'd0;
            if (st.valid_acc[VB_EP] && st.first_char != CH_DASH) begin
               sm_res.square_rank    = 3'(st.second_char - CH_ONE);
               sm_res.square_file    = 3'(st.first_char - CH_LA);
               sm_res.en_passant_set = 1'b1;
            end
            sm_res.halfmove_count = 16'(st.halfmove_hold);
            sm_res.fullmove_count = st.valid_acc[VB_FULL] ? 16'(st.number_acc) : 16'd0;
         end else begin
            sm_res.valid_mask = {5'b0, st.valid_acc[VB_BOARD]};
         end
         st.in_record = 1'b0;
      end

      clr_res.last = !pc_v && !sm_v;
      pc_res.last  = !sm_v;
      sm_res.last  = 1'b1;
   end

   // pack present results in order
   always_comb begin
      n_res  = {1'b0, clr_v} + {1'b0, pc_v} + {1'b0, sm_v};
      res[0] = clr_v ? clr_res : (pc_v ? pc_res : sm_res);
      res[1] = (clr_v && pc_v) ? pc_res : sm_res;
      res[2] = sm_res;
   end

   // result queue: head at entry 0, shift on pop, append behind
   always_comb begin
      base = cnt_ff - QCNT_W'(pop);
      off  = '0;
      for (int i = 0; i < QDEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_in[QDEPTH-1] = q_ff[QDEPTH-1];
      for (int i = 0; i < QDEPTH; i++) begin
         off = QCNT_W'(i) - base;
         if (fire && QCNT_W'(i) >= base && off < QCNT_W'(n_res)) begin
            q_in[i] = res[off[1:0]];
         end
      end
      cnt_in = base + (fire ? QCNT_W'(n_res) : QCNT_W'(0));
      st_in  = fire ? st : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue count out of range");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      fire && req_data.end_of_record |=> !st_ff.in_record)
      else $error("record still open after end byte");

   a_clear_queued: assert property (@(posedge clock) disable iff (reset)
      fire && !st_ff.in_record |=> cnt_ff != '0)
      else $error("first byte of record queued no clear result");

   a_piece_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_PIECE |-> rsp_data.piece_code <= PC_BK)
      else $error("piece result with bad piece code");
`endif

endmodule

`default_nettype wire

/* sim/tb_fen_record_parser.sv */
// tb_fen_record_parser: self-checking bench for the FEN record parser.
// Depends on fenrp_pkg and fen_record_parser; predicts every result word
// from the bytes sent and checks each rsp word against it.
module tb_fen_record_parser;
   import fenrp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int             WATCHDOG_LIMIT = 2000;
   localparam int             BOARD_SIZE     = 8;
   localparam logic [31:0]    COUNT_MAX      = (32'd1 << COUNT_BITS) - 1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int         mismatches   = 0;
   int         quiet_cycles = 0;
   bit         idling       = 1'b1;
   rsp_type    pending_results[$];
   logic [7:0] line_buf[$];

   // parser state as predicted from the accepted bytes
   logic                  rec_open = 1'b0;
   logic [2:0]            fld_idx;
   logic [3:0]            rank_idx;
   logic [3:0]            file_cnt;
   logic                  board_err;
   logic                  slash_seen;
   logic [1:0]            fld_len;
   logic [7:0]            char_a;
   logic [7:0]            char_b;
   logic [4:0]            castle_seen;
   logic [31:0]           num_value;
   logic [4:0]            num_flags;
   logic [5:0]            field_ok;
   logic [COUNT_BITS-1:0] half_value;
   logic                  side_b;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fen_record_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic bit number_ok(input int least);
      if (!num_flags[NF_DIGITS] || num_flags[NF_OVF])
         return 1'b0;
      if (num_flags[NF_NEG] && num_value != 0)
         return 1'b0;
      return num_value >= least;
   endfunction

   task automatic close_field(input logic [2:0] idx);
      bit ok;
      case (idx)
         FLD_BOARD: begin
            ok = !board_err && ((slash_seen && rank_idx == BOARD_SIZE) ||
                 (!slash_seen && rank_idx == BOARD_SIZE - 1 && file_cnt == BOARD_SIZE));
            field_ok[VB_BOARD] = ok;
         end
         FLD_SIDE: begin
            ok = fld_len == 1 && (char_a == CH_LW || char_a == CH_LO_B);
            side_b = ok && char_a == CH_LO_B;
            field_ok[VB_SIDE] = ok;
         end
         FLD_CASTLE: field_ok[VB_CASTLE] = !castle_seen[CB_BAD];
         FLD_EP: begin
            ok = (fld_len == 1 && char_a == CH_DASH) ||
                 (fld_len == 2 && char_a >= CH_LA && char_a <= CH_LH &&
                  char_b >= CH_ONE && char_b <= CH_EIGHT);
            field_ok[VB_EP] = ok;
         end
         FLD_HALF: begin
            ok = number_ok(0);
            half_value = ok ? num_value[COUNT_BITS-1:0] : '0;
            field_ok[VB_HALF] = ok;
         end
         FLD_FULL: field_ok[VB_FULL] = number_ok(1);
         default: ;
      endcase
   endtask

   // Works out the result words that one accepted byte causes.
   task automatic parse_byte(input logic [7:0] c, input logic eor);
      rsp_type    r;
      rsp_type    outs[$];
      logic [1:0] prev_len;
      logic [3:0] digit_n;
      logic [7:0] diff;
      int         pc;
      int         tokens;
      bit         is_digit;
      bit         skip;

      if (!rec_open) begin
         fld_idx = '0; rank_idx = '0; file_cnt = '0; board_err = 1'b0;
         slash_seen = 1'b0; fld_len = '0; char_a = '0; char_b = '0;
         castle_seen = '0; num_value = '0; num_flags = '0; field_ok = '0;
         half_value = '0; side_b = 1'b0;
         r = '0;
         r.result_kind = KIND_CLEAR;
         outs.insert(outs.size(), r);
         rec_open = 1'b1;
      end

      if (c == CH_SPACE) begin
         close_field(fld_idx);
         if (fld_idx < FLD_MAX)
            fld_idx++;
         fld_len = '0;
         if (fld_idx == FLD_CASTLE)
            castle_seen = '0;
         if (fld_idx == FLD_HALF || fld_idx == FLD_FULL) begin
            num_value = '0;
            num_flags = '0;
         end
      end else begin
         prev_len = fld_len;
         if (fld_len < 3)
            fld_len++;
         case (fld_idx)
            FLD_BOARD: begin
               if (c == CH_SLASH) begin
                  if (rank_idx >= BOARD_SIZE || file_cnt != BOARD_SIZE)
                     board_err = 1'b1;
                  if (rank_idx < BOARD_SIZE)
                     rank_idx++;
                  file_cnt = '0;
                  slash_seen = 1'b1;
               end else begin
                  slash_seen = 1'b0;
                  case (c)
                     CH_UP_P: pc = PC_WP;
                     CH_UP_N: pc = PC_WN;
                     CH_UP_B: pc = PC_WB;
                     CH_UP_R: pc = PC_WR;
                     CH_UP_Q: pc = PC_WQ;
                     CH_UP_K: pc = PC_WK;
                     CH_LO_P: pc = PC_BP;
                     CH_LO_N: pc = PC_BN;
                     CH_LO_B: pc = PC_BB;
                     CH_LO_R: pc = PC_BR;
                     CH_LO_Q: pc = PC_BQ;
                     CH_LO_K: pc = PC_BK;
                     default: pc = -1;
                  endcase
                  if (c >= CH_ONE && c <= CH_EIGHT) begin
                     // low nibble of '1'..'8' is the run length
                     digit_n = c[3:0];
                     if (rank_idx >= BOARD_SIZE || int'(file_cnt) + int'(digit_n) > BOARD_SIZE)
                        board_err = 1'b1;
                     else
                        file_cnt = file_cnt + digit_n;
                  end else if (pc < 0 || rank_idx >= BOARD_SIZE || file_cnt >= BOARD_SIZE) begin
                     board_err = 1'b1;
                  end else if (board_err) begin
                     file_cnt++;
                  end else begin
                     r = '0;
                     r.result_kind = KIND_PIECE;
                     r.square_rank = 3'd7 - rank_idx[2:0];
                     r.square_file = file_cnt[2:0];
                     r.piece_code  = pc[3:0];
                     outs.insert(outs.size(), r);
                     file_cnt++;
                  end
               end
            end
            FLD_SIDE: if (prev_len == 0) char_a = c;
            FLD_CASTLE: begin
               if (c == CH_UP_K)      castle_seen[CB_WK] = 1'b1;
               else if (c == CH_UP_Q) castle_seen[CB_WQ] = 1'b1;
               else if (c == CH_LO_K) castle_seen[CB_BK] = 1'b1;
               else if (c == CH_LO_Q) castle_seen[CB_BQ] = 1'b1;
               else if (c != CH_DASH) castle_seen[CB_BAD] = 1'b1;
            end
            FLD_EP: begin
               if (prev_len == 0)      char_a = c;
               else if (prev_len == 1) char_b = c;
            end
            FLD_HALF, FLD_FULL: begin
               is_digit = c >= CH_ZERO && c <= CH_NINE;
               if (!num_flags[NF_BAD]) begin
                  skip = 1'b0;
                  // blanks and one sign may precede the digits
                  if (!num_flags[NF_STARTED]) begin
                     if (c >= CH_TAB && c <= CH_CR) begin
                        skip = 1'b1;
                     end else if (c == CH_PLUS || c == CH_DASH) begin
                        num_flags[NF_STARTED] = 1'b1;
                        if (c == CH_DASH)
                           num_flags[NF_NEG] = 1'b1;
                        skip = 1'b1;
                     end else if (!is_digit) begin
                        num_flags[NF_BAD] = 1'b1;
                        skip = 1'b1;
                     end else begin
                        num_flags[NF_STARTED] = 1'b1;
                     end
                  end
                  if (!skip) begin
                     if (!is_digit) begin
                        num_flags[NF_BAD] = 1'b1;
                     end else begin
                        num_flags[NF_DIGITS] = 1'b1;
                        if (!num_flags[NF_OVF]) begin
                           num_value = num_value * 10 + (c - CH_ZERO);
                           if (num_value > COUNT_MAX)
                              num_flags[NF_OVF] = 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (eor) begin
         close_field(fld_idx);
         tokens = int'(fld_idx) + ((fld_len != 0) ? 1 : 0);
         r = '0;
         r.result_kind = KIND_SUMMARY;
         if (field_ok[VB_BOARD] && tokens > FLD_FULL) begin
            r.valid_mask  = field_ok;
            r.side_black  = side_b;
            r.castle_bits = field_ok[VB_CASTLE] ? castle_seen[3:0] : 4'd0;
            if (field_ok[VB_EP] && char_a != CH_DASH) begin
               diff = char_b - CH_ONE;
               r.square_rank = diff[2:0];
               diff = char_a - CH_LA;
               r.square_file = diff[2:0];
               r.en_passant_set = 1'b1;
            end
            r.halfmove_count = half_value;
            r.fullmove_count = field_ok[VB_FULL] ? num_value[15:0] : 16'd0;
         end else begin
            r.valid_mask = {5'd0, field_ok[VB_BOARD]};
         end
         outs.insert(outs.size(), r);
         rec_open = 1'b0;
      end

      if (outs.size() > 0)
         outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i])
         pending_results.insert(pending_results.size(), outs[i]);
   endtask

   task automatic send_word(input logic [7:0] code, input logic eor);
      req_type w;
      w.char_code = code;
      w.end_of_record = eor;
      while (idling && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      parse_byte(code, eor);
   endtask

   task automatic send_line;
      for (int i = 0; i < line_buf.size(); i++)
         send_word(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // Holds the sender off until every expected word has come back.
   task automatic wait_drained;
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
   endtask

   task automatic add_char(input logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i]);
   endtask

   // halfmove / fullmove text: mostly legal, plus and minus sign, blank, range corners, junk
   task automatic push_number;
      logic [7:0] blank;
      case ($urandom_range(0, 11))
         0: push_text("0");
         1: push_text("1");
         2: push_text($sformatf("%0d", $urandom_range(2, 300)));
         3: push_text($sformatf("%0d", COUNT_MAX));
         4: push_text($sformatf("%0d", COUNT_MAX + 1));
         5: push_text($sformatf("%0d", $urandom_range(70000, 99999999)));
         6: push_text($sformatf("-%0d", $urandom_range(1, 99)));
         7: push_text("-0");
         8: push_text($sformatf("+%0d", $urandom_range(0, 99)));
         9: begin
            blank = 8'($urandom_range(CH_TAB, CH_CR));
            add_char(blank);
            push_text($sformatf("%03d", $urandom_range(0, 999)));
         end
         10: push_text($sformatf("%0dx", $urandom_range(0, 99)));
         default: push_text("+");
      endcase
   endtask

   task automatic build_formed_record;
      string      pieces;
      string      rights;
      int         f;
      int         n;
      int         pos;
      logic [7:0] b;
      pieces = "PNBRQKpnbrqk";
      rights = "KQkq";
      for (int rk = 0; rk < BOARD_SIZE; rk++) begin
         f = 0;
         while (f < BOARD_SIZE) begin
            if ($urandom_range(99) < 45) begin
               n = $urandom_range(1, BOARD_SIZE - f);
               b = CH_ZERO + 8'(n);
               add_char(b);
               f += n;
            end else begin
               add_char(pieces[$urandom_range(0, 11)]);
               f++;
            end
         end
         if (rk < BOARD_SIZE - 1 || $urandom_range(9) == 0)
            add_char(CH_SLASH);
      end

      push_text(" ");
      n = $urandom_range(99);
      if (n < 45)      add_char(CH_LW);
      else if (n < 90) add_char(CH_LO_B);
      else             push_text("bw");

      push_text(" ");
      pos = line_buf.size();
      for (int i = 0; i < 4; i++)
         if ($urandom_range(99) < 50)
            add_char(rights[$urandom_range(0, 3)]);
      if ($urandom_range(9) == 0)
         add_char(CH_LW);
      if (line_buf.size() == pos)
         add_char(CH_DASH);

      push_text(" ");
      if ($urandom_range(99) < 40) begin
         add_char(CH_DASH);
      end else begin
         // one step past h and 8 now and then
         b = CH_LA + 8'($urandom_range(0, 8));
         add_char(b);
         b = CH_ONE + 8'($urandom_range(0, 8));
         add_char(b);
      end

      push_text(" ");
      push_number();
      push_text(" ");
      push_number();
      if ($urandom_range(9) == 0)
         push_text(" xyz");
      if ($urandom_range(9) == 0)
         push_text(" ");

      // broken record: overwrite, drop, insert or cut short
      if ($urandom_range(99) < 25) begin
         pos = $urandom_range(0, line_buf.size() - 1);
         b = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0: line_buf[pos] = b;
            1: line_buf.delete(pos);
            2: line_buf.insert(pos, b);
            default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
         endcase
      end
   endtask

   task automatic test_single_byte_records;
      logic [7:0] codes[5];
      codes = '{8'h00, 8'hFF, CH_SPACE, CH_LO_K, CH_SLASH};
      foreach (codes[i])
         send_word(codes[i], 1'b1);
   endtask

   task automatic test_trailing_slash_board;
      push_text("8/8/8/8/8/8/8/8/");
      send_line();
   endtask

   task automatic test_formed_records(input int byte_budget);
      int sent;
      sent = 0;
      while (sent < byte_budget) begin
         build_formed_record();
         sent += line_buf.size();
         send_line();
      end
   endtask

   task automatic test_burst_records;
      idling = 1'b0;
      repeat (2) begin
         build_formed_record();
         send_line();
      end
      idling = 1'b1;
   endtask

   task automatic test_noise_records;
      logic [7:0] b;
      repeat (6) begin
         repeat ($urandom_range(1, 8)) begin
            b = 8'($urandom_range(0, 255));
            add_char(b);
         end
         send_line();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: kind %0d", rsp_data.result_kind);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("result_kind", 32'(want.result_kind),
                           32'(rsp_data.result_kind));
               check_field("square_rank", 32'(want.square_rank),
                           32'(rsp_data.square_rank));
               check_field("square_file", 32'(want.square_file),
                           32'(rsp_data.square_file));
               check_field("piece_code", 32'(want.piece_code),
                           32'(rsp_data.piece_code));
               check_field("valid_mask", 32'(want.valid_mask),
                           32'(rsp_data.valid_mask));
               check_field("side_black", 32'(want.side_black),
                           32'(rsp_data.side_black));
               check_field("castle_bits", 32'(want.castle_bits),
                           32'(rsp_data.castle_bits));
               check_field("en_passant_set", 32'(want.en_passant_set),
                           32'(rsp_data.en_passant_set));
               check_field("halfmove_count", 32'(want.halfmove_count),
                           32'(rsp_data.halfmove_count));
               check_field("fullmove_count", 32'(want.fullmove_count),
                           32'(rsp_data.fullmove_count));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         rsp_ready <= !(idling && $urandom_range(99) < 19);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_single_byte_records();
      test_trailing_slash_board();
      test_formed_records(50);
      wait_drained();
      test_burst_records();
      test_noise_records();
      wait_drained();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
